### rtl/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BTE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define BTE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### rtl/bte_pkg.sv
package bte_pkg;

	// Table sizes and field widths.
	localparam int MAX_EDGES  = 8192;
	localparam int MAX_NODES  = 1024;
	localparam int VALUE_BITS = 16;
	localparam int EDGE_BITS  = 13;
	localparam int NODE_BITS  = 10;
	localparam int OP_BITS    = 2;

	// A score is the exact sum of three values, so two more bits suffice.
	localparam int SCORE_BITS = VALUE_BITS + 2;

	// Operation codes.
	localparam logic [OP_BITS-1:0] OP_LOAD_EDGE = 2'd0;
	localparam logic [OP_BITS-1:0] OP_LOAD_NODE = 2'd1;
	localparam logic [OP_BITS-1:0] OP_SCORE     = 2'd2;

	// Control that travels with a score beat into the selection unit.
	typedef struct packed {
		logic                 active;
		logic                 scored;
		logic                 last;
		logic [EDGE_BITS-1:0] index;
	} score_ctrl_t;

endpackage

### rtl/bte_edge_mem.sv
module bte_edge_mem import bte_pkg::*; (
	input  logic                 clk,
	input  logic                 wr_en,
	input  logic [EDGE_BITS-1:0] wr_addr,
	input  logic [NODE_BITS-1:0] wr_source,
	input  logic [NODE_BITS-1:0] wr_target,
	input  logic                 rd_en,
	input  logic [EDGE_BITS-1:0] rd_addr,
	output logic [NODE_BITS-1:0] rd_source,
	output logic [NODE_BITS-1:0] rd_target
);

	logic [2*NODE_BITS-1:0] edge_mem [MAX_EDGES];
	logic [2*NODE_BITS-1:0] rd_data_q;

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			edge_mem[wr_addr] <= {wr_source, wr_target};
		end
		if (rd_en) begin
			rd_data_q <= edge_mem[rd_addr];
		end
	end

	assign rd_source = rd_data_q[2*NODE_BITS-1:NODE_BITS];
	assign rd_target = rd_data_q[NODE_BITS-1:0];

endmodule

### rtl/bte_node_mem.sv
module bte_node_mem import bte_pkg::*; (
	input  logic                         clk,
	input  logic                         wr_en,
	input  logic [NODE_BITS-1:0]         wr_addr,
	input  logic signed [VALUE_BITS-1:0] wr_present,
	input  logic signed [VALUE_BITS-1:0] wr_next,
	input  logic                         rd_en,
	input  logic [NODE_BITS-1:0]         rd_present_addr,
	input  logic [NODE_BITS-1:0]         rd_next_addr,
	output logic signed [VALUE_BITS-1:0] rd_present,
	output logic signed [VALUE_BITS-1:0] rd_next
);

	logic [VALUE_BITS-1:0] present_mem [MAX_NODES];
	logic [VALUE_BITS-1:0] next_mem [MAX_NODES];
	logic [VALUE_BITS-1:0] present_q;
	logic [VALUE_BITS-1:0] next_q;

	// Both tables share a write address; each has its own read address.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			present_mem[wr_addr] <= wr_present;
			next_mem[wr_addr]    <= wr_next;
		end
		if (rd_en) begin
			present_q <= present_mem[rd_present_addr];
			next_q    <= next_mem[rd_next_addr];
		end
	end

	assign rd_present = $signed(present_q);
	assign rd_next    = $signed(next_q);

endmodule

### rtl/bte_select.sv
module bte_select import bte_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  score_ctrl_t                  ctrl,
	input  logic signed [VALUE_BITS-1:0] weight,
	input  logic signed [VALUE_BITS-1:0] present,
	input  logic signed [VALUE_BITS-1:0] next_value,
	input  logic [NODE_BITS-1:0]         source,
	input  logic [NODE_BITS-1:0]         target,
	input  logic                         load_wr,
	input  logic [EDGE_BITS-1:0]         load_addr,
	input  logic [NODE_BITS-1:0]         load_source,
	input  logic [NODE_BITS-1:0]         load_target,
	output logic                         hold,
	output logic                         result_valid,
	input  logic                         result_stall,
	output logic                         found,
	output logic [EDGE_BITS-1:0]         best_edge,
	output logic [NODE_BITS-1:0]         best_source,
	output logic [NODE_BITS-1:0]         best_target
);

	logic signed [SCORE_BITS-1:0] score;
	logic signed [SCORE_BITS-1:0] best_score_q;
	logic [EDGE_BITS-1:0]         best_index_q;
	logic [NODE_BITS-1:0]         best_src_q;
	logic [NODE_BITS-1:0]         best_tgt_q;
	logic                         have_best_q;
	logic                         take;
	logic                         fire;
	logic                         res_valid_q;
	logic                         found_q;
	logic [EDGE_BITS-1:0]         edge_q;
	logic [NODE_BITS-1:0]         src_q;
	logic [NODE_BITS-1:0]         tgt_q;

	// Exact score and comparison with the running best; ties keep the older edge.
	assign score = SCORE_BITS'(present) + SCORE_BITS'(next_value) + SCORE_BITS'(weight);
	assign take  = ctrl.scored && (!have_best_q || (score > best_score_q));

	// A closing beat waits while the previous result is still held downstream.
	assign hold = ctrl.active && ctrl.last && res_valid_q && result_stall;
	assign fire = ctrl.active && !hold;

	// Running best; it returns to zero once a pass has been closed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_score_q <= '0;
			best_index_q <= '0;
			have_best_q  <= 1'b0;
		end else if (fire) begin
			if (ctrl.last) begin
				best_score_q <= '0;
				best_index_q <= '0;
				have_best_q  <= 1'b0;
			end else if (take) begin
				best_score_q <= score;
				best_index_q <= ctrl.index;
				have_best_q  <= 1'b1;
			end
		end
	end

	// Endpoints of the best edge travel with it, and an edge load that rewrites that
	// entry in mid-pass updates them, so the copy always matches the edge table.
	always_ff @(posedge clk) begin
		if (fire && take) begin
			best_src_q <= source;
			best_tgt_q <= target;
		end else if (load_wr && (load_addr == best_index_q)) begin
			best_src_q <= load_source;
			best_tgt_q <= load_target;
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fire && ctrl.last) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	// Output register payload; an empty pass reports all zeros.
	always_ff @(posedge clk) begin
		if (fire && ctrl.last) begin
			if (take) begin
				found_q <= 1'b1;
				edge_q  <= ctrl.index;
				src_q   <= source;
				tgt_q   <= target;
			end else if (have_best_q) begin
				found_q <= 1'b1;
				edge_q  <= best_index_q;
				src_q   <= best_src_q;
				tgt_q   <= best_tgt_q;
			end else begin
				found_q <= 1'b0;
				edge_q  <= '0;
				src_q   <= '0;
				tgt_q   <= '0;
			end
		end
	end

	assign result_valid = res_valid_q;
	assign found        = found_q;
	assign best_edge    = edge_q;
	assign best_source  = src_q;
	assign best_target  = tgt_q;

endmodule

### rtl/best_transition_edge_select.sv
// Load beats (operations 0 and 1) write the tables directly and do not occupy the block.
// A score beat goes through an edge table read, a node table read, then score and compare.
// A closing score beat shows its result from the output register after score and compare, later if the output is held.
// The two dependent memory reads are not overlapped: the input stalls until a score beat has finished.
// Reset clears the sequencer, the running best and the output valid flag at once.
// The tables are not cleared by reset and hold whatever was last written.
module best_transition_edge_select import bte_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	output logic                         item_stall,
	input  logic [OP_BITS-1:0]           operation,
	input  logic [EDGE_BITS-1:0]         item_index,
	input  logic [NODE_BITS-1:0]         source_node,
	input  logic [NODE_BITS-1:0]         target_node,
	input  logic signed [VALUE_BITS-1:0] value_a,
	input  logic signed [VALUE_BITS-1:0] value_b,
	input  logic                         last_edge,
	output logic                         result_valid,
	input  logic                         result_stall,
	output logic                         found,
	output logic [EDGE_BITS-1:0]         best_edge,
	output logic [NODE_BITS-1:0]         best_source,
	output logic [NODE_BITS-1:0]         best_target
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EDGE = 2'd1;
	localparam logic [1:0] ST_NODE = 2'd2;

	logic [1:0]                   state_q;
	logic                         accept;
	logic                         edge_wr;
	logic                         node_wr;
	logic                         score_go;
	logic                         hold;
	logic [NODE_BITS-1:0]         edge_src;
	logic [NODE_BITS-1:0]         edge_tgt;
	logic signed [VALUE_BITS-1:0] node_present;
	logic signed [VALUE_BITS-1:0] node_next;
	logic [EDGE_BITS-1:0]         index_s1;
	logic signed [VALUE_BITS-1:0] weight_s1;
	logic                         last_s1;
	logic                         scored_s1;
	logic [EDGE_BITS-1:0]         index_s2;
	logic signed [VALUE_BITS-1:0] weight_s2;
	logic                         last_s2;
	logic                         scored_s2;
	logic [NODE_BITS-1:0]         src_s2;
	logic [NODE_BITS-1:0]         tgt_s2;
	score_ctrl_t                  ctrl;

	// Input handshake and beat decode.
	assign item_stall = (state_q != ST_IDLE);
	assign accept     = item_valid && !item_stall;
	assign edge_wr    = accept && (operation == OP_LOAD_EDGE) && (int'(item_index) < MAX_EDGES);
	assign node_wr    = accept && (operation == OP_LOAD_NODE) && (int'(item_index) < MAX_NODES);
	assign score_go   = accept && (operation == OP_SCORE);

	// Sequencer for a score beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (score_go) begin
						state_q <= ST_EDGE;
					end
				end
				ST_EDGE: begin
					state_q <= ST_NODE;
				end
				ST_NODE: begin
					if (!hold) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Stage registers alongside the two memory reads.
	always_ff @(posedge clk) begin
		if (score_go) begin
			index_s1  <= item_index;
			weight_s1 <= value_a;
			last_s1   <= last_edge;
			scored_s1 <= (int'(item_index) < MAX_EDGES);
		end
		if (state_q == ST_EDGE) begin
			index_s2  <= index_s1;
			weight_s2 <= weight_s1;
			last_s2   <= last_s1;
			scored_s2 <= scored_s1;
			src_s2    <= edge_src;
			tgt_s2    <= edge_tgt;
		end
	end

	bte_edge_mem u_edge_mem (
		.clk       (clk),
		.wr_en     (edge_wr),
		.wr_addr   (item_index),
		.wr_source (source_node),
		.wr_target (target_node),
		.rd_en     (score_go),
		.rd_addr   (item_index),
		.rd_source (edge_src),
		.rd_target (edge_tgt)
	);

	bte_node_mem u_node_mem (
		.clk             (clk),
		.wr_en           (node_wr),
		.wr_addr         (item_index[NODE_BITS-1:0]),
		.wr_present      (value_a),
		.wr_next         (value_b),
		.rd_en           (state_q == ST_EDGE),
		.rd_present_addr (edge_src),
		.rd_next_addr    (edge_tgt),
		.rd_present      (node_present),
		.rd_next         (node_next)
	);

	// Control for the selection stage.
	always_comb begin
		ctrl.active = (state_q == ST_NODE);
		ctrl.scored = scored_s2;
		ctrl.last   = last_s2;
		ctrl.index  = index_s2;
	end

	bte_select u_select (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.weight       (weight_s2),
		.present      (node_present),
		.next_value   (node_next),
		.source       (src_s2),
		.target       (tgt_s2),
		.load_wr      (edge_wr),
		.load_addr    (item_index),
		.load_source  (source_node),
		.load_target  (target_node),
		.hold         (hold),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.found        (found),
		.best_edge    (best_edge),
		.best_source  (best_source),
		.best_target  (best_target)
	);

endmodule

### rtl/bte_checker.sv
`include "assert_macros.svh"

module bte_checker import bte_pkg::*; (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         item_valid,
	input logic                         item_stall,
	input logic [OP_BITS-1:0]           operation,
	input logic [EDGE_BITS-1:0]         item_index,
	input logic [NODE_BITS-1:0]         source_node,
	input logic [NODE_BITS-1:0]         target_node,
	input logic signed [VALUE_BITS-1:0] value_a,
	input logic signed [VALUE_BITS-1:0] value_b,
	input logic                         last_edge,
	input logic                         result_valid,
	input logic                         result_stall,
	input logic                         found,
	input logic [EDGE_BITS-1:0]         best_edge,
	input logic [NODE_BITS-1:0]         best_source,
	input logic [NODE_BITS-1:0]         best_target
);

	// A result beat held by the receiver keeps its valid and its payload.
	`BTE_ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && result_stall, result_valid && $stable({found, best_edge, best_source, best_target}))

	// A score beat occupies the block for the following cycles.
	`BTE_ASSERT_NEXT(a_score_busy, clk, arst_n, item_valid && !item_stall && (operation == OP_SCORE), item_stall)

	// Load beats and unused codes never occupy the block.
	`BTE_ASSERT_NEXT(a_load_free, clk, arst_n, item_valid && !item_stall && (operation != OP_SCORE), !item_stall)

	// An empty pass reports zeroed fields.
	`BTE_ASSERT_SAME(a_empty_zero, clk, arst_n, result_valid && !found, (best_edge == '0) && (best_source == '0) && (best_target == '0))

endmodule

bind best_transition_edge_select bte_checker u_bte_checker (.*);
